// ===== rtl/hmp_pkg.sv =====
// ---------------------------------------------------------------------------
// Horner polynomial package
// Shared codes, item type and helpers for the multi-output Horner evaluator.
// ---------------------------------------------------------------------------
package hmp_pkg;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_TERMS_IN_USE   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUTS_IN_USE = 4'd1;

   localparam int RESULT_LIMIT = 8;

   typedef struct packed {
      logic        is_eval;
      logic [2:0]  term;
      logic [2:0]  sel;
      logic [31:0] coeff;
      logic [31:0] x;
      logic [3:0]  nterms;
      logic [2:0]  oidx;
      logic        last;
   } item_type;

   function automatic int addr_width(input int depth);
      addr_width = (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// ===== rtl/hmp_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ---------------------------------------------------------------------------
module hmp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [hmp_pkg::addr_width(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [hmp_pkg::addr_width(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hmp_issue.sv =====
// ---------------------------------------------------------------------------
// Horner request issue stage
// Takes requests, expands an evaluate request into one item per output,
// holds coefficient bank 0 and the stage that loads the first coefficient.
// ---------------------------------------------------------------------------
module hmp_issue #(
   parameter int MAX_TERMS   = 8,
   parameter int MAX_OUTPUTS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [2:0]          req_term_index,
   input  logic [2:0]          req_output_select,
   input  logic signed [31:0]  req_coefficient,
   input  logic signed [31:0]  req_x_value,
   input  logic [3:0]          terms_cfg,
   input  logic [3:0]          outputs_cfg,
   output logic                dn_valid,
   output hmp_pkg::item_type   dn_item,
   output logic [31:0]         dn_acc,
   output logic                dn_sat,
   input  logic                dn_ready
);

   localparam int ADDR_W = hmp_pkg::addr_width(MAX_OUTPUTS);
   localparam int TERMS_CAP = (MAX_TERMS > 15) ? 15 : MAX_TERMS;
   localparam int OUT_CAP = (MAX_OUTPUTS > hmp_pkg::RESULT_LIMIT) ?
                            hmp_pkg::RESULT_LIMIT : MAX_OUTPUTS;
   localparam logic [3:0] TERMS_HI = 4'(TERMS_CAP);
   localparam logic [3:0] OUT_HI   = 4'(OUT_CAP);

   logic              p0_valid_ff, p0_valid_in;
   hmp_pkg::item_type p0_item_ff, p0_item_in;
   logic [2:0]        p0_o_ff, p0_o_in;
   logic [2:0]        p0_last_ff, p0_last_in;
   logic              a0_valid_ff, a0_valid_in;
   hmp_pkg::item_type a0_item_ff, a0_item_in;

   logic [3:0] nterms_w, nout_w;
   logic       a0_ready, p0_go, p0_final, accept, bank_we;

   always_comb begin
      if (terms_cfg == 4'd0) begin
         nterms_w = 4'd1;
      end else if (terms_cfg > TERMS_HI) begin
         nterms_w = TERMS_HI;
      end else begin
         nterms_w = terms_cfg;
      end
      if (outputs_cfg == 4'd0) begin
         nout_w = 4'd1;
      end else if (outputs_cfg > OUT_HI) begin
         nout_w = OUT_HI;
      end else begin
         nout_w = outputs_cfg;
      end
   end

   assign a0_ready  = !a0_valid_ff || dn_ready;
   assign p0_go     = p0_valid_ff && a0_ready;
   assign p0_final  = !p0_item_ff.is_eval || (p0_o_ff == p0_last_ff);
   assign req_ready = !p0_valid_ff || (a0_ready && p0_final);
   assign accept    = req_valid && req_ready;

   always_comb begin
      p0_valid_in = p0_valid_ff;
      p0_item_in  = p0_item_ff;
      p0_o_in     = p0_o_ff;
      p0_last_in  = p0_last_ff;
      if (accept) begin
         p0_valid_in        = 1'b1;
         p0_item_in.is_eval = (req_operation == hmp_pkg::OP_EVAL);
         p0_item_in.term    = req_term_index;
         p0_item_in.sel     = req_output_select;
         p0_item_in.coeff   = req_coefficient;
         p0_item_in.x       = req_x_value;
         p0_item_in.nterms  = nterms_w;
         p0_item_in.oidx    = 3'd0;
         p0_item_in.last    = 1'b0;
         p0_o_in            = 3'd0;
         p0_last_in         = 3'(nout_w - 4'd1);
      end else if (p0_go && !p0_final) begin
         p0_o_in = p0_o_ff + 3'd1;
      end else if (p0_go) begin
         p0_valid_in = 1'b0;
      end
   end

   always_comb begin
      a0_valid_in = a0_valid_ff;
      a0_item_in  = a0_item_ff;
      if (a0_ready) begin
         a0_valid_in     = p0_valid_ff;
         a0_item_in      = p0_item_ff;
         a0_item_in.oidx = p0_o_ff;
         a0_item_in.last = p0_item_ff.is_eval && (p0_o_ff == p0_last_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         a0_valid_ff <= 1'b0;
      end else begin
         p0_valid_ff <= p0_valid_in;
         a0_valid_ff <= a0_valid_in;
      end
      p0_item_ff <= p0_item_in;
      p0_o_ff    <= p0_o_in;
      p0_last_ff <= p0_last_in;
      a0_item_ff <= a0_item_in;
   end

   assign bank_we = p0_go && !p0_item_ff.is_eval && (p0_item_ff.term == 3'd0) &&
                    (32'(p0_item_ff.sel) < 32'(MAX_OUTPUTS));

   hmp_ram #(
      .WIDTH (32),
      .DEPTH (MAX_OUTPUTS)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (bank_we),
      .wr_addr (ADDR_W'(p0_item_ff.sel)),
      .wr_data (p0_item_ff.coeff),
      .rd_en   (a0_ready),
      .rd_addr (ADDR_W'(p0_o_ff)),
      .rd_data (dn_acc)
   );

   assign dn_valid = a0_valid_ff;
   assign dn_item  = a0_item_ff;
   assign dn_sat   = 1'b0;

   a_o_range: assert property (@(posedge clock) disable iff (reset)
      p0_valid_ff && p0_item_ff.is_eval |-> p0_o_ff <= p0_last_ff)
      else $error("output counter beyond last output");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> p0_valid_ff && (p0_o_ff == 3'd0))
      else $error("accepted request does not start at output zero");

   a_last_eval: assert property (@(posedge clock) disable iff (reset)
      a0_valid_ff && a0_item_ff.last |-> a0_item_ff.is_eval)
      else $error("last mark on a write item");

endmodule

// ===== rtl/hmp_step.sv =====
// ---------------------------------------------------------------------------
// Horner step
// One Horner iteration: coefficient bank K, a multiply stage and a
// shift, add and saturate stage.
// ---------------------------------------------------------------------------
module hmp_step #(
   parameter int K           = 1,
   parameter int MAX_OUTPUTS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   input  hmp_pkg::item_type  up_item,
   input  logic [31:0]        up_acc,
   input  logic               up_sat,
   output logic               up_ready,
   output logic               dn_valid,
   output hmp_pkg::item_type  dn_item,
   output logic [31:0]        dn_acc,
   output logic               dn_sat,
   input  logic               dn_ready
);

   localparam int ADDR_W = hmp_pkg::addr_width(MAX_OUTPUTS);

   logic              m_valid_ff;
   hmp_pkg::item_type m_item_ff;
   logic [31:0]       m_acc_ff;
   logic              m_sat_ff;
   logic [63:0]       m_prod_ff;
   logic              a_valid_ff;
   hmp_pkg::item_type a_item_ff;
   logic [31:0]       a_acc_ff, a_acc_in;
   logic              a_sat_ff, a_sat_in;

   logic               m_ready, a_ready, bank_we, active, clip;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_w;
   logic [31:0]        coeff_w;
   logic [47:0]        prod_sh;
   logic [48:0]        sum_w;

   assign a_ready  = !a_valid_ff || dn_ready;
   assign m_ready  = !m_valid_ff || a_ready;
   assign up_ready = m_ready;

   assign bank_we = up_valid && m_ready && !up_item.is_eval &&
                    (32'(up_item.term) == 32'(K)) &&
                    (32'(up_item.sel) < 32'(MAX_OUTPUTS));

   hmp_ram #(
      .WIDTH (32),
      .DEPTH (MAX_OUTPUTS)
   ) u_bank (
      .clock   (clock),
      .wr_en   (bank_we),
      .wr_addr (ADDR_W'(up_item.sel)),
      .wr_data (up_item.coeff),
      .rd_en   (m_ready),
      .rd_addr (ADDR_W'(up_item.oidx)),
      .rd_data (coeff_w)
   );

   assign mul_a = up_acc;
   assign mul_b = up_item.x;
   assign mul_w = mul_a * mul_b;

   assign prod_sh = m_prod_ff[63:16];
   assign sum_w   = {{17{coeff_w[31]}}, coeff_w} + {prod_sh[47], prod_sh};
   assign clip    = (sum_w[48:31] != {18{1'b0}}) && (sum_w[48:31] != {18{1'b1}});
   assign active  = 32'(m_item_ff.nterms) > 32'(K);

   always_comb begin
      a_acc_in = m_acc_ff;
      a_sat_in = m_sat_ff;
      if (active) begin
         a_sat_in = m_sat_ff || clip;
         if (clip) begin
            a_acc_in = sum_w[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            a_acc_in = sum_w[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         if (m_ready) begin
            m_valid_ff <= up_valid;
         end
         if (a_ready) begin
            a_valid_ff <= m_valid_ff;
         end
      end
      if (m_ready) begin
         m_item_ff <= up_item;
         m_acc_ff  <= up_acc;
         m_sat_ff  <= up_sat;
         m_prod_ff <= mul_w;
      end
      if (a_ready) begin
         a_item_ff <= m_item_ff;
         a_acc_ff  <= a_acc_in;
         a_sat_ff  <= a_sat_in;
      end
   end

   assign dn_valid = a_valid_ff;
   assign dn_item  = a_item_ff;
   assign dn_acc   = a_acc_ff;
   assign dn_sat   = a_sat_ff;

endmodule

// ===== rtl/multi_output_horner_polynomial.sv =====
// ---------------------------------------------------------------------------
// Multi-output Horner polynomial evaluator
// Evaluates up to eight signed Q16.16 polynomials at one point.
// ---------------------------------------------------------------------------
// Usage:
//   csr_ channel: write terms_in_use (index 0) and outputs_in_use (index 1)
//   while the block is idle; csr_ready is always high.
//   req_ channel: a write request stores one coefficient (term 0 is the
//   highest order); an evaluate request gives one rsp_ item per output in
//   use, in output order, with rsp_last on the final one.
//   Throughput: one result per cycle while rsp_ready stays high; an
//   evaluate request holds the input until its last output item moves on,
//   and a write request until it moves on itself. The pipeline has one
//   multiply stage and one add/saturate stage per Horner step.
//   Reset empties the pipeline and sets both registers to 1; the
//   coefficient banks are not cleared and must be written before use.
//   A stalled receiver holds the last stage; earlier stages keep filling
//   bubbles and then hold, and req_ready drops once the pipeline is full.
// ---------------------------------------------------------------------------
module multi_output_horner_polynomial #(
   parameter int MAX_TERMS   = 8,
   parameter int MAX_OUTPUTS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hmp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [hmp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic [2:0]                           req_term_index,
   input  logic [2:0]                           req_output_select,
   input  logic signed [31:0]                   req_coefficient,
   input  logic signed [31:0]                   req_x_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_output_index,
   output logic signed [31:0]                   rsp_y_value,
   output logic                                 rsp_saturated,
   output logic                                 rsp_last
);

   logic [3:0] terms_ff, outputs_ff;

   logic              ch_valid [MAX_TERMS];
   hmp_pkg::item_type ch_item  [MAX_TERMS];
   logic [31:0]       ch_acc   [MAX_TERMS];
   logic              ch_sat   [MAX_TERMS];
   logic              ch_ready [MAX_TERMS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         terms_ff   <= 4'd1;
         outputs_ff <= 4'd1;
      end else if (csr_valid) begin
         if (csr_index == hmp_pkg::CSR_TERMS_IN_USE) begin
            terms_ff <= csr_wdata;
         end else if (csr_index == hmp_pkg::CSR_OUTPUTS_IN_USE) begin
            outputs_ff <= csr_wdata;
         end
      end
   end

   hmp_issue #(
      .MAX_TERMS   (MAX_TERMS),
      .MAX_OUTPUTS (MAX_OUTPUTS)
   ) u_issue (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_term_index    (req_term_index),
      .req_output_select (req_output_select),
      .req_coefficient   (req_coefficient),
      .req_x_value       (req_x_value),
      .terms_cfg         (terms_ff),
      .outputs_cfg       (outputs_ff),
      .dn_valid          (ch_valid[0]),
      .dn_item           (ch_item[0]),
      .dn_acc            (ch_acc[0]),
      .dn_sat            (ch_sat[0]),
      .dn_ready          (ch_ready[0])
   );

   for (genvar k = 1; k < MAX_TERMS; k++) begin : g_step
      hmp_step #(
         .K           (k),
         .MAX_OUTPUTS (MAX_OUTPUTS)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .up_valid (ch_valid[k-1]),
         .up_item  (ch_item[k-1]),
         .up_acc   (ch_acc[k-1]),
         .up_sat   (ch_sat[k-1]),
         .up_ready (ch_ready[k-1]),
         .dn_valid (ch_valid[k]),
         .dn_item  (ch_item[k]),
         .dn_acc   (ch_acc[k]),
         .dn_sat   (ch_sat[k]),
         .dn_ready (ch_ready[k])
      );
   end

   // drop write requests at the end of the pipeline
   assign rsp_valid = ch_valid[MAX_TERMS-1] && ch_item[MAX_TERMS-1].is_eval;
   assign ch_ready[MAX_TERMS-1] = !rsp_valid || rsp_ready;

   assign rsp_output_index = ch_item[MAX_TERMS-1].oidx;
   assign rsp_y_value      = ch_acc[MAX_TERMS-1];
   assign rsp_saturated    = ch_sat[MAX_TERMS-1];
   assign rsp_last         = ch_item[MAX_TERMS-1].last;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
